### hw/rtl/bslp_pkg.sv
// Shared types and constants for the button short/long press detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bslp_pkg;

   localparam int LEVEL_W              = 6;
   localparam int IDX_W                = 3;
   localparam int TICK_W               = 16;
   localparam int DEFAULT_BUTTON_COUNT = 6;
   localparam int REQ_DATA_W           = 8;
   localparam int RSP_DATA_W           = 8;
   localparam int CSR_ADDR_W           = 1;

   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TICK_W-1:0] LONG_RESET     = 16'd1000;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_TICKS   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS_TICKS = 1'b1;

   typedef enum logic [1:0] {
      EV_BEEP  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_WAIT    = 4'b0010,
      PH_PRESSED = 4'b0100,
      PH_HELD    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic start;
      logic stop;
   } timer_ctrl_type;

   typedef struct packed {
      logic                 emit;
      kind_type             kind;
      logic [IDX_W-1:0]     button;
   } event_type;

endpackage

### hw/rtl/button_short_long_press_detector.sv
// Each accepted transfer is one tick of sampled button levels. The tick enters an input
// register; once it advances, it updates the press sequencer and, when it causes an event,
// loads the result register. One tick is taken every cycle; the only stall is a held
// result that the sink has not taken.
// Depends on bslp_pkg, bslp_ctrl and bslp_timer.
`timescale 1ns / 1ps

module button_short_long_press_detector
   import bslp_pkg::*;
#(
   parameter int unsigned BUTTON_COUNT = DEFAULT_BUTTON_COUNT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [5:0] button_levels
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [1:0] event_kind, [4:2] button_index
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [TICK_W-1:0]      csr_wdata
);

   logic [TICK_W-1:0]  debounce_ff, long_press_ff;
   logic               in_valid_ff;
   logic [LEVEL_W-1:0] in_levels_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               advance;
   event_type          result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE_TICKS:   debounce_ff   <= csr_wdata;
            CSR_LONG_PRESS_TICKS: long_press_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_levels_ff <= req_tdata[LEVEL_W-1:0];
      end
   end

   bslp_ctrl #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .levels           (in_levels_ff),
      .debounce_ticks   (debounce_ff),
      .long_press_ticks (long_press_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && result.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         rsp_data_ff <= {3'b000, result.button, result.kind};
      end
   end

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[1:0] != 2'd3))
      else $error("result carries an undefined event kind");

   a_button_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[4:2] < IDX_W'(LEVEL_W)))
      else $error("result carries a button index beyond the level vector");

   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a processed tick");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_levels_ff)))
      else $error("pending tick lost while the result was stalled");

endmodule

### hw/rtl/bslp_timer.sv
// Tick timer: counts while running, stops at its limit and flags the hit.
// Depends on bslp_pkg.
`timescale 1ns / 1ps

module bslp_timer
   import bslp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  timer_ctrl_type      ctrl,
   input  logic [TICK_W-1:0]   limit,
   output logic                hit
);

   logic [TICK_W-1:0] count_ff, count_in;
   logic              running_ff, running_in;
   logic [TICK_W-1:0] count_next;

   assign count_next = count_ff + 1'b1;
   assign hit        = running_ff && (count_next >= limit);

   always_comb begin
      count_in   = count_ff;
      running_in = running_ff;
      if (advance) begin
         if (ctrl.start) begin
            count_in   = '0;
            running_in = 1'b1;
         end else if (ctrl.stop) begin
            count_in   = '0;
            running_in = 1'b0;
         end else if (running_ff) begin
            count_in   = count_next;
            running_in = !hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         running_ff <= running_in;
      end
   end

endmodule

### hw/rtl/bslp_ctrl.sv
// Press sequencer: edge capture, debounce and hold timers, phase logic.
// Depends on bslp_pkg and bslp_timer.
`timescale 1ns / 1ps

module bslp_ctrl
   import bslp_pkg::*;
#(
   parameter int unsigned BUTTON_COUNT = DEFAULT_BUTTON_COUNT
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [LEVEL_W-1:0]  levels,
   input  logic [TICK_W-1:0]   debounce_ticks,
   input  logic [TICK_W-1:0]   long_press_ticks,
   output event_type           result
);

   phase_type          phase_ff, phase_in;
   logic [LEVEL_W-1:0] prev_ff, prev_in;
   logic               pending_ff, pending_in;
   logic               done_ff, done_in;
   logic               long_ff, long_in;
   logic [IDX_W-1:0]   cap_ff, cap_in;

   logic [LEVEL_W-1:0] mask;
   logic [LEVEL_W-1:0] lv;
   logic [LEVEL_W-1:0] rising;
   logic [7:0]         lv_ext;
   logic               held;
   logic               deb_hit, hold_hit;
   logic               done_t, long_t;
   timer_ctrl_type     deb_ctrl, hold_ctrl;

   always_comb begin
      for (int i = 0; i < LEVEL_W; i++) begin
         mask[i] = (i < BUTTON_COUNT);
      end
   end

   assign lv     = levels & mask;
   assign rising = lv & ~prev_ff;
   assign lv_ext = {{(8-LEVEL_W){1'b0}}, lv};
   assign done_t = done_ff | deb_hit;
   assign long_t = long_ff | hold_hit;

   always_comb begin
      prev_in    = lv;
      pending_in = pending_ff | (|rising);
      cap_in     = cap_ff;
      for (int i = 0; i < LEVEL_W; i++) begin
         if (rising[i]) begin
            cap_in = IDX_W'(i);
         end
      end
      held          = lv_ext[cap_in];
      phase_in      = phase_ff;
      done_in       = done_t;
      long_in       = long_t;
      deb_ctrl      = '0;
      hold_ctrl     = '0;
      result.emit   = 1'b0;
      result.kind   = EV_BEEP;
      result.button = cap_in;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pending_in && done_t) begin
               pending_in      = 1'b0;
               hold_ctrl.start = 1'b1;
               long_in         = 1'b0;
               deb_ctrl.start  = 1'b1;
               done_in         = 1'b0;
               phase_in        = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (done_t) begin
               done_in     = 1'b0;
               phase_in    = PH_PRESSED;
               result.emit = 1'b1;
               result.kind = EV_BEEP;
            end
         end
         PH_PRESSED: begin
            if (long_t) begin
               long_in     = 1'b0;
               phase_in    = PH_HELD;
               result.emit = 1'b1;
               result.kind = EV_LONG;
            end else if (!held) begin
               hold_ctrl.stop = 1'b1;
               deb_ctrl.start = 1'b1;
               done_in        = 1'b0;
               phase_in       = PH_IDLE;
               result.emit    = 1'b1;
               result.kind    = EV_SHORT;
            end
         end
         PH_HELD: begin
            if (!held) begin
               deb_ctrl.start = 1'b1;
               done_in        = 1'b0;
               phase_in       = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   bslp_timer u_debounce (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctrl    (deb_ctrl),
      .limit   (debounce_ticks),
      .hit     (deb_hit)
   );

   bslp_timer u_hold (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctrl    (hold_ctrl),
      .limit   (long_press_ticks),
      .hit     (hold_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         prev_ff    <= '0;
         pending_ff <= 1'b0;
         done_ff    <= 1'b1;
         long_ff    <= 1'b0;
         cap_ff     <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         pending_ff <= pending_in;
         done_ff    <= done_in;
         long_ff    <= long_in;
         cap_ff     <= cap_in;
      end
   end

endmodule
